// ----- src/rmth_pkg.sv -----
// Shared types and defaults for the two-heap running median block.
package rmth_pkg;

	localparam int unsigned HEAP_DEPTH_DEF   = 512;
	localparam int unsigned SAMPLE_WIDTH_DEF = 32;

	// Heap select: the lower half is a max-heap, the upper half a min-heap.
	localparam logic HEAP_LOWER = 1'b0;
	localparam logic HEAP_UPPER = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PUSH_START,
		OP_UP_READ,
		OP_UP_STEP,
		OP_PUT,
		OP_DOWN_START,
		OP_DN_READ1,
		OP_DN_READ2,
		OP_DN_STEP,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic sel;      // heap to work on
		logic src_top;  // push the other heap's top instead of the sample
		logic drop;     // item was dropped, storage full
	} cmd_t;

	typedef struct packed {
		logic full;
		logic uempty;
		logic equal;
		logic x_ge_ltop;
		logic x_gt_utop;
		logic idx_zero;
		logic c_end;
		logic up_go;
		logic down_go;
	} sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_UP_RD,
		S_UP_STEP,
		S_DN_START,
		S_DN_RD1,
		S_DN_RD2,
		S_DN_STEP,
		S_OUT
	} state_t;

endpackage

// ----- src/rmth_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rmth_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/rmth_datapath.sv -----
// Heap storage, sift index, cached tops, size counters and result register.
module rmth_datapath import rmth_pkg::*; #(
	parameter int unsigned HEAP_DEPTH   = HEAP_DEPTH_DEF,
	parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cmd_t                                  cmd,
	output sts_t                                  sts,
	input  logic [SAMPLE_WIDTH-1:0]               sample,
	input  logic                                  restart,
	output logic [SAMPLE_WIDTH-1:0]               median,
	output logic                                  median_valid,
	output logic [$clog2(2*HEAP_DEPTH+1)-1:0]     sample_count,
	output logic                                  dropped
);

	localparam int unsigned AW  = $clog2(HEAP_DEPTH);
	localparam int unsigned SZW = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned CW  = $clog2(2 * HEAP_DEPTH + 1);
	localparam int unsigned IW  = AW + 2;

	logic [SAMPLE_WIDTH-1:0] x_q, val_q, best_q, ltop_q, utop_q;
	logic [AW-1:0]           idx_q, bidx_q;
	logic [SZW-1:0]          lsize_q, usize_q;
	logic                    hsel_q;

	logic [SAMPLE_WIDTH-1:0] lrd, urd, rd, cand, wdata;
	logic [AW-1:0]           par, cidx, waddr, raddr;
	logic [IW-1:0]           c1, c2, size_ext;
	logic [SZW-1:0]          size_sel;
	logic                    we, has2, up_go, down_go;

	logic [SAMPLE_WIDTH-1:0] median_q;
	logic                    mvalid_q, drop_q;
	logic [CW-1:0]           count_q;

	// a ranks nearer the root than b
	function automatic logic above(input logic is_min, input logic [SAMPLE_WIDTH-1:0] a,
			input logic [SAMPLE_WIDTH-1:0] b);
		above = is_min ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
	endfunction

	assign rd       = hsel_q ? urd : lrd;
	assign size_sel = hsel_q ? usize_q : lsize_q;
	assign size_ext = IW'(size_sel);
	assign c1       = {1'b0, idx_q, 1'b1};
	assign c2       = c1 + IW'(1);
	assign has2     = c2 < size_ext;
	assign par      = AW'((idx_q - AW'(1)) >> 1);
	assign up_go    = above(hsel_q, val_q, rd);
	assign cand     = (has2 && above(hsel_q, rd, best_q)) ? rd : best_q;
	assign cidx     = (has2 && above(hsel_q, rd, best_q)) ? c2[AW-1:0] : bidx_q;
	assign down_go  = above(hsel_q, cand, val_q);

	always_comb begin
		sts.full      = (lsize_q == SZW'(HEAP_DEPTH)) && (usize_q == SZW'(HEAP_DEPTH));
		sts.uempty    = usize_q == '0;
		sts.equal     = usize_q == lsize_q;
		sts.x_ge_ltop = !($signed(x_q) < $signed(ltop_q));
		sts.x_gt_utop = $signed(utop_q) < $signed(x_q);
		sts.idx_zero  = idx_q == '0;
		sts.c_end     = c1 >= size_ext;
		sts.up_go     = up_go;
		sts.down_go   = down_go;
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = val_q;
		raddr = par;
		unique case (cmd.op)
			OP_UP_STEP: begin
				we    = 1'b1;
				wdata = up_go ? rd : val_q;
			end
			OP_PUT: we = 1'b1;
			OP_DN_READ1: raddr = c1[AW-1:0];
			OP_DN_READ2: raddr = c2[AW-1:0];
			OP_DN_STEP: begin
				we    = 1'b1;
				wdata = down_go ? cand : val_q;
			end
			default: ;
		endcase
	end

	rmth_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HEAP_DEPTH)) u_lower (
		.clk   (clk),
		.we    (we && (hsel_q == HEAP_LOWER)),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (lrd)
	);

	rmth_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HEAP_DEPTH)) u_upper (
		.clk   (clk),
		.we    (we && (hsel_q == HEAP_UPPER)),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (urd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsize_q <= '0;
			usize_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (restart) begin
						lsize_q <= '0;
						usize_q <= '0;
					end
				end
				OP_PUSH_START: begin
					if (cmd.sel == HEAP_UPPER) usize_q <= usize_q + SZW'(1);
					else                       lsize_q <= lsize_q + SZW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// keep the roots in registers so decisions never wait on a read
		if (we && (waddr == '0)) begin
			if (hsel_q == HEAP_UPPER) utop_q <= wdata;
			else                      ltop_q <= wdata;
		end
		case (cmd.op)
			OP_LOAD: x_q <= sample;
			OP_PUSH_START: begin
				hsel_q <= cmd.sel;
				val_q  <= cmd.src_top ? ((cmd.sel == HEAP_UPPER) ? ltop_q : utop_q) : x_q;
				idx_q  <= (cmd.sel == HEAP_UPPER) ? usize_q[AW-1:0] : lsize_q[AW-1:0];
			end
			OP_UP_STEP: begin
				if (up_go) idx_q <= par;
			end
			OP_DOWN_START: begin
				hsel_q <= cmd.sel;
				val_q  <= x_q;
				idx_q  <= '0;
			end
			OP_DN_READ2: begin
				best_q <= rd;
				bidx_q <= c1[AW-1:0];
			end
			OP_DN_STEP: begin
				if (down_go) idx_q <= cidx;
			end
			OP_OUT: begin
				median_q <= (usize_q != '0) ? utop_q : '0;
				count_q  <= CW'(lsize_q) + CW'(usize_q);
				mvalid_q <= lsize_q[0] ^ usize_q[0];
				drop_q   <= cmd.drop;
			end
			default: ;
		endcase
	end

	assign median       = median_q;
	assign median_valid = mvalid_q;
	assign sample_count = count_q;
	assign dropped      = drop_q;

endmodule

// ----- src/rmth_ctrl.sv -----
// Sequencer: placement decision, sift-up and sift-down steps, handshakes.
module rmth_ctrl import rmth_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   psel_q, psel_d, dodown_q, dodown_d, drop_q, drop_d, mvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			psel_q   <= HEAP_UPPER;
			dodown_q <= 1'b0;
			drop_q   <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			psel_q   <= psel_d;
			dodown_q <= dodown_d;
			drop_q   <= drop_d;
			if (cmd.op == OP_OUT)  mvalid_q <= 1'b1;
			else if (m_tready)     mvalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d     = state_q;
		psel_d      = psel_q;
		dodown_d    = dodown_q;
		drop_d      = drop_q;
		cmd.op      = OP_NONE;
		cmd.sel     = psel_q;
		cmd.src_top = 1'b0;
		cmd.drop    = drop_q;
		s_tready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.full) begin
					drop_d  = 1'b1;
					state_d = S_OUT;
				end else begin
					drop_d = 1'b0;
					if (sts.uempty) begin
						psel_d      = HEAP_UPPER;
						dodown_d    = 1'b0;
					end else if (sts.equal) begin
						psel_d      = HEAP_UPPER;
						dodown_d    = !sts.x_ge_ltop;
					end else begin
						psel_d      = HEAP_LOWER;
						dodown_d    = sts.x_gt_utop;
					end
					cmd.op      = OP_PUSH_START;
					cmd.sel     = psel_d;
					cmd.src_top = dodown_d;
					state_d     = S_UP_RD;
				end
			end
			S_UP_RD: begin
				if (sts.idx_zero) begin
					cmd.op  = OP_PUT;
					state_d = dodown_q ? S_DN_START : S_OUT;
				end else begin
					cmd.op  = OP_UP_READ;
					state_d = S_UP_STEP;
				end
			end
			S_UP_STEP: begin
				cmd.op  = OP_UP_STEP;
				if (sts.up_go)     state_d = S_UP_RD;
				else if (dodown_q) state_d = S_DN_START;
				else               state_d = S_OUT;
			end
			S_DN_START: begin
				// the sample replaces the other heap's root and sinks
				cmd.op  = OP_DOWN_START;
				cmd.sel = !psel_q;
				state_d = S_DN_RD1;
			end
			S_DN_RD1: begin
				if (sts.c_end) begin
					cmd.op  = OP_PUT;
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_DN_READ1;
					state_d = S_DN_RD2;
				end
			end
			S_DN_RD2: begin
				cmd.op  = OP_DN_READ2;
				state_d = S_DN_STEP;
			end
			S_DN_STEP: begin
				cmd.op  = OP_DN_STEP;
				state_d = sts.down_go ? S_DN_RD1 : S_OUT;
			end
			S_OUT: begin
				// hold until the result register is free
				if (!mvalid_q || m_tready) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign m_tvalid = mvalid_q;

endmodule

// ----- src/running_median_two_heaps_top.sv -----
// One item at a time; a dropped item goes from the decision state straight to the result register.
// Other items are sifted up (read the parent, then step) and, where needed, sifted down in the other
// heap (read both children, then step), both through the single read port of each heap memory.
// The next item is accepted while a finished result waits in the output register.
// Reset (arst_n low) empties both heaps at once; heap memory contents are not cleared.
module running_median_two_heaps_top import rmth_pkg::*; #(
	parameter int unsigned HEAP_DEPTH   = HEAP_DEPTH_DEF,
	parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// sample
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	// restart
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// median, median_valid, sample_count, dropped
	output logic [((SAMPLE_WIDTH+$clog2(2*HEAP_DEPTH+1)+2+7)/8)*8-1:0] m_tdata
);

	localparam int unsigned CW  = $clog2(2 * HEAP_DEPTH + 1);
	localparam int unsigned ODW = ((SAMPLE_WIDTH + CW + 2 + 7) / 8) * 8;

	cmd_t cmd;
	sts_t sts;
	logic [SAMPLE_WIDTH-1:0] median;
	logic                    median_valid, dropped;
	logic [CW-1:0]           sample_count;

	rmth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmth_datapath #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (s_tdata[SAMPLE_WIDTH-1:0]),
		.restart      (s_tuser),
		.median       (median),
		.median_valid (median_valid),
		.sample_count (sample_count),
		.dropped      (dropped)
	);

	assign m_tdata = ODW'({dropped, sample_count, median_valid, median});

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dropped |-> sample_count == CW'(2 * HEAP_DEPTH))
		else $error("item dropped while storage not full");

	a_never_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> sample_count != '0)
		else $error("result reports empty heaps");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> median_valid == sample_count[0])
		else $error("median_valid disagrees with count parity");

endmodule
